[rtl/nts_pkg.sv]
`default_nettype none

package nts_pkg;

    // defaults of the top level parameters
    localparam int PHASE_BITS_DEF = 32;
    localparam int SINE_DEPTH_DEF = 1024;

    // field widths
    localparam int FREQ_W  = 24;
    localparam int START_W = 24;
    localparam int DUR_W   = 16;
    localparam int TONE_W  = 22;
    localparam int GAP_W   = 30;
    localparam int END_W   = 25;
    localparam int AMP_W   = 15;
    localparam int SAMP_W  = 16;

    // frequency is given in 1/256 Hz
    localparam int FREQ_FRAC_BITS = 8;

    // phase step divider: remainder width and quotient bits per stage
    localparam int REM_W      = 16;
    localparam int RADIX_BITS = 4;
    localparam logic [REM_W:0] RATE_HZ = 17'd44100;

    // ms to samples: ms*44 + floor(ms/10), the division by reciprocal
    localparam int             MS_WHOLE    = 44;
    localparam int             DIV10_MUL_W = 26;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 26'd53687092;
    localparam int             DIV10_SHIFT = 29;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_LOAD_OK   = 2'd1,
        KIND_LOAD_BUSY = 2'd2,
        KIND_IDLE      = 2'd3
    } kind_t;

    // item as it travels through the step divider
    typedef struct packed {
        logic               op;
        logic [FREQ_W-1:0]  freq;
        logic [START_W-1:0] start;
        logic [DUR_W-1:0]   dur;
        logic [TONE_W-1:0]  tone_cnt;
    } front_t;

    // result as it leaves the note state stage
    typedef struct packed {
        kind_t kind;
        logic  last;
        logic  is_sine;
    } res_t;

    function automatic logic [GAP_W-1:0] ms_to_samples(input logic [START_W-1:0] ms);
        logic [START_W+DIV10_MUL_W-1:0] prod;
        prod = (START_W+DIV10_MUL_W)'(ms) * (START_W+DIV10_MUL_W)'(DIV10_MUL);
        return GAP_W'(ms) * GAP_W'(MS_WHOLE) + GAP_W'(prod >> DIV10_SHIFT);
    endfunction

endpackage

`default_nettype wire

[rtl/nts_div_stage.sv]
`default_nettype none

module nts_div_stage #(
    parameter int PHASE_BITS = nts_pkg::PHASE_BITS_DEF,
    parameter int STAGE      = 0
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         valid_i,
    output logic                              ready_o,
    input  wire nts_pkg::front_t              item_i,
    input  wire logic [nts_pkg::REM_W-1:0]    rem_i,
    input  wire logic [PHASE_BITS-1:0]        quot_i,
    output logic                              valid_o,
    input  wire logic                         ready_i,
    output nts_pkg::front_t                   item_o,
    output logic [nts_pkg::REM_W-1:0]         rem_o,
    output logic [PHASE_BITS-1:0]             quot_o
);

    localparam int SHIFT   = PHASE_BITS - nts_pkg::FREQ_FRAC_BITS;
    localparam int DVD_W   = nts_pkg::FREQ_W + SHIFT;
    localparam int NSTG    = (DVD_W + nts_pkg::RADIX_BITS - 1) / nts_pkg::RADIX_BITS;
    localparam int DVD_PAD = NSTG * nts_pkg::RADIX_BITS;
    localparam int TOP     = DVD_PAD - 1 - STAGE * nts_pkg::RADIX_BITS;

    logic                          valid_reg;
    nts_pkg::front_t               item_reg;
    logic [nts_pkg::REM_W-1:0]     rem_reg;
    logic [nts_pkg::REM_W-1:0]     rem_next;
    logic [PHASE_BITS-1:0]         quot_reg;
    logic [PHASE_BITS-1:0]         quot_next;
    logic [DVD_PAD-1:0]            dividend;
    logic [nts_pkg::RADIX_BITS-1:0] chunk;

    assign dividend = DVD_PAD'(item_i.freq) << SHIFT;
    assign chunk    = dividend[TOP -: nts_pkg::RADIX_BITS];

    // restoring division, one quotient bit per dividend bit
    always_comb begin : div_steps
        logic [nts_pkg::REM_W:0] wide;
        rem_next  = rem_i;
        quot_next = quot_i;
        for (int i = 0; i < nts_pkg::RADIX_BITS; i++) begin
            wide = {rem_next, chunk[nts_pkg::RADIX_BITS-1-i]};
            if (wide >= nts_pkg::RATE_HZ) begin
                wide      = wide - nts_pkg::RATE_HZ;
                quot_next = {quot_next[PHASE_BITS-2:0], 1'b1};
            end else begin
                quot_next = {quot_next[PHASE_BITS-2:0], 1'b0};
            end
            rem_next = wide[nts_pkg::REM_W-1:0];
        end
    end

    assign ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
        if (ready_o && valid_i) begin
            item_reg <= item_i;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign valid_o = valid_reg;
    assign item_o  = item_reg;
    assign rem_o   = rem_reg;
    assign quot_o  = quot_reg;

endmodule

`default_nettype wire

[rtl/nts_sine_rom.sv]
`default_nettype none

module nts_sine_rom #(
    parameter int SINE_TABLE_DEPTH = nts_pkg::SINE_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                en,
    input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
    output logic signed [nts_pkg::SAMP_W-1:0]        data
);

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] FULL_SCALE  = 64'd32767;

    typedef logic signed [nts_pkg::SAMP_W-1:0] rom_t [SINE_TABLE_DEPTH];

    // round(32767*sin(2*pi*k/depth)) from a q30 taylor series on the folded angle
    function automatic logic signed [nts_pkg::SAMP_W-1:0] sine_entry(input int k);
        logic [63:0]        turn;
        logic [63:0]        quad;
        logic [63:0]        f;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic signed [63:0] s;
        turn = (64'(k) << 32) / SINE_TABLE_DEPTH;
        quad = (turn >> 30) & 64'd3;
        f    = turn & (Q30_ONE - 64'd1);
        if (quad[0]) begin
            f = Q30_ONE - f;
        end
        x    = (f * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        s    = $signed(x);
        term = ((x * x2) >> 30) / 64'd6;
        s    = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        s    = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        s    = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        s    = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        s    = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        s    = s + $signed(term);
        if (s < 0) begin
            s = 64'sd0;
        end
        mag = ($unsigned(s) * FULL_SCALE + (Q30_ONE >> 1)) >> 30;
        if (mag > FULL_SCALE) begin
            mag = FULL_SCALE;
        end
        if (quad >= 64'd2) begin
            return -$signed(nts_pkg::SAMP_W'(mag));
        end
        return $signed(nts_pkg::SAMP_W'(mag));
    endfunction

    function automatic rom_t build_table();
        rom_t t;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_table();

    always_ff @(posedge aclk) begin
        if (en) begin
            data <= SINE_ROM[addr];
        end
    end

endmodule

`default_nettype wire

[rtl/nts_sample_scale.sv]
`default_nettype none

module nts_sample_scale (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire nts_pkg::res_t                      in_res,
    input  wire logic signed [nts_pkg::SAMP_W-1:0]  in_entry,
    input  wire logic [nts_pkg::AMP_W-1:0]          amplitude,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output nts_pkg::kind_t                          out_kind,
    output logic                                    out_last,
    output logic signed [nts_pkg::SAMP_W-1:0]       out_sample
);

    localparam int PROD_W = 2 * nts_pkg::AMP_W;
    // floor(p/32767) = (p*RECIP) >> 45, exact for p below 2^30
    localparam int                 RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP       = 31'd1073774594;
    localparam int                 RECIP_SHIFT = 45;

    logic                        adv_m;
    logic                        adv_q;
    logic [nts_pkg::AMP_W-1:0]   mag;
    logic [nts_pkg::SAMP_W-1:0]  neg_entry;
    logic [PROD_W+RECIP_W-1:0]   recip_prod;
    logic [nts_pkg::AMP_W-1:0]   quo;

    // product stage
    logic                        m_valid_reg;
    nts_pkg::res_t               m_res_reg;
    logic                        m_neg_reg;
    logic [PROD_W-1:0]           m_prod_reg;

    // divide stage, also the output register
    logic                        q_valid_reg;
    nts_pkg::kind_t              q_kind_reg;
    logic                        q_last_reg;
    logic signed [nts_pkg::SAMP_W-1:0] q_sample_reg;

    assign adv_q    = !q_valid_reg || out_ready;
    assign adv_m    = !m_valid_reg || adv_q;
    assign in_ready = adv_m;

    assign neg_entry  = -in_entry;
    assign mag        = in_entry[nts_pkg::SAMP_W-1] ? neg_entry[nts_pkg::AMP_W-1:0]
                                                    : in_entry[nts_pkg::AMP_W-1:0];
    assign recip_prod = (PROD_W+RECIP_W)'(m_prod_reg) * (PROD_W+RECIP_W)'(RECIP);
    assign quo        = nts_pkg::AMP_W'(recip_prod >> RECIP_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end else begin
            if (adv_m) begin
                m_valid_reg <= in_valid;
            end
            if (adv_q) begin
                q_valid_reg <= m_valid_reg;
            end
        end
        if (adv_m && in_valid) begin
            m_res_reg <= in_res;
            m_neg_reg <= in_entry[nts_pkg::SAMP_W-1];
            // silence and non-sample results scale to zero
            m_prod_reg <= in_res.is_sine ? PROD_W'(mag) * PROD_W'(amplitude) : '0;
        end
        if (adv_q && m_valid_reg) begin
            q_kind_reg   <= m_res_reg.kind;
            q_last_reg   <= m_res_reg.last;
            q_sample_reg <= m_neg_reg ? -$signed(nts_pkg::SAMP_W'(quo))
                                      : $signed(nts_pkg::SAMP_W'(quo));
        end
    end

    assign out_valid  = q_valid_reg;
    assign out_kind   = q_kind_reg;
    assign out_last   = q_last_reg;
    assign out_sample = q_sample_reg;

endmodule

`default_nettype wire

[rtl/note_tone_sequencer_unit.sv]
`default_nettype none

// note tone sequencer: turns a stream of note loads and sample ticks into
// 16-bit mono samples from a sine table, one result per input transfer
//
// input channel s_*: tuser[0] is the opcode (load or tick), tdata carries
// the note fields; each accepted transfer yields exactly one result on m_*
// (sample, load accepted, load refused busy, or idle tick), in order
//
// an input transfer passes a radix-16 divider pipeline that forms the phase
// step, one note state stage with the sine table read, and two stages that
// scale by the amplitude before m_tvalid; one transfer per cycle is
// sustained while m_tready is high
//
// the apb port holds the amplitude register at address 0; write it only
// while no transfer is in flight
//
// reset empties every stage, clears the note state and sets the amplitude
// to full scale; the stages are elastic, so while m_tready is low the
// pipeline fills its bubbles and s_tready drops only once every stage
// holds an item
module note_tone_sequencer_unit #(
    parameter int PHASE_BITS       = nts_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = nts_pkg::SINE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // note_freq[23:0], note_start_ms[47:24],
                                        // note_duration_ms[63:48]
    input  wire logic [0:0]  s_tuser,   // opcode[0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // sample[15:0]
    output logic [1:0]       m_tuser,   // kind[1:0]
    output logic             m_tlast,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SHIFT   = PHASE_BITS - nts_pkg::FREQ_FRAC_BITS;
    localparam int DVD_W   = nts_pkg::FREQ_W + SHIFT;
    localparam int NSTG    = (DVD_W + nts_pkg::RADIX_BITS - 1) / nts_pkg::RADIX_BITS;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int IDXP_W  = PHASE_BITS + IDX_W + 1;

    localparam logic REG_AMPLITUDE = 1'b0;
    localparam logic [nts_pkg::AMP_W-1:0] AMP_RESET = 15'd32767;

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    logic [nts_pkg::AMP_W-1:0] amp_reg;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // register index is the word address
    assign prdata    = (paddr[2] == REG_AMPLITUDE) ? 32'(amp_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_reg <= AMP_RESET;
        end else if (cfg_write && paddr[2] == REG_AMPLITUDE) begin
            amp_reg <= pwdata[nts_pkg::AMP_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // phase step divider: floor(freq * 2^(PHASE_BITS-8) / 44100)
    // ---------------------------------------------------------------
    logic                      dv_valid [NSTG+1];
    logic                      dv_ready [NSTG+1];
    nts_pkg::front_t           dv_item  [NSTG+1];
    logic [nts_pkg::REM_W-1:0] dv_rem   [NSTG+1];
    logic [PHASE_BITS-1:0]     dv_quot  [NSTG+1];

    // the tone length needs no state, so it is formed on entry
    assign dv_valid[0]          = s_tvalid;
    assign dv_item[0].op        = s_tuser[0];
    assign dv_item[0].freq      = s_tdata[23:0];
    assign dv_item[0].start     = s_tdata[47:24];
    assign dv_item[0].dur       = s_tdata[63:48];
    assign dv_item[0].tone_cnt  = nts_pkg::TONE_W'(nts_pkg::ms_to_samples(
                                      nts_pkg::START_W'(s_tdata[63:48])));
    assign dv_rem[0]            = '0;
    assign dv_quot[0]           = '0;
    assign s_tready             = dv_ready[0];

    for (genvar k = 0; k < NSTG; k++) begin : g_div
        nts_div_stage #(
            .PHASE_BITS (PHASE_BITS),
            .STAGE      (k)
        ) u_div_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .valid_i (dv_valid[k]),
            .ready_o (dv_ready[k]),
            .item_i  (dv_item[k]),
            .rem_i   (dv_rem[k]),
            .quot_i  (dv_quot[k]),
            .valid_o (dv_valid[k+1]),
            .ready_i (dv_ready[k+1]),
            .item_o  (dv_item[k+1]),
            .rem_o   (dv_rem[k+1]),
            .quot_o  (dv_quot[k+1])
        );
    end

    // ---------------------------------------------------------------
    // note state stage
    // ---------------------------------------------------------------
    nts_pkg::front_t           it;
    logic                      take;
    logic                      adv_s;
    logic                      sc_ready;
    logic                      gap_busy;
    logic                      tone_busy;
    logic                      load_ok;
    logic [nts_pkg::GAP_W-1:0] gap_conv;
    logic [IDXP_W-1:0]         idx_prod;
    logic [IDX_W-1:0]          rom_addr;
    logic signed [nts_pkg::SAMP_W-1:0] rom_data;

    logic                        s_valid_reg, s_valid_next;
    nts_pkg::res_t               s_res_reg,   s_res_next;
    // a new gap is held in ms and converted to samples in the next cycle
    logic                        gap_pend_reg, gap_pend_next;
    logic [nts_pkg::START_W-1:0] gap_ms_reg,   gap_ms_next;
    logic [nts_pkg::GAP_W-1:0]   gap_left_reg, gap_left_next;
    logic [nts_pkg::TONE_W-1:0]  tone_left_reg, tone_left_next;
    logic                        tone_en_reg,  tone_en_next;
    logic [nts_pkg::END_W-1:0]   prev_end_reg, prev_end_next;
    logic [PHASE_BITS-1:0]       acc_reg,      acc_next;
    logic [PHASE_BITS-1:0]       step_reg,     step_next;

    assign it        = dv_item[NSTG];
    assign adv_s     = !s_valid_reg || sc_ready;
    assign take      = dv_valid[NSTG] && adv_s;
    assign dv_ready[NSTG] = adv_s;
    assign gap_busy  = gap_pend_reg || (gap_left_reg != '0);
    assign tone_busy = tone_left_reg != '0;
    assign load_ok   = take && (it.op == nts_pkg::OP_LOAD) && !gap_busy && !tone_busy;
    assign gap_conv  = nts_pkg::ms_to_samples(gap_ms_reg);

    // table index = (phase * depth) >> PHASE_BITS
    assign idx_prod  = IDXP_W'(acc_reg) * IDXP_W'(SINE_TABLE_DEPTH);
    assign rom_addr  = IDX_W'(idx_prod >> PHASE_BITS);

    always_comb begin
        s_valid_next   = s_valid_reg;
        s_res_next     = s_res_reg;
        gap_pend_next  = 1'b0;
        gap_ms_next    = gap_ms_reg;
        gap_left_next  = gap_pend_reg ? gap_conv : gap_left_reg;
        tone_left_next = tone_left_reg;
        tone_en_next   = tone_en_reg;
        prev_end_next  = prev_end_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;

        if (adv_s) begin
            s_valid_next       = dv_valid[NSTG];
            s_res_next.kind    = nts_pkg::KIND_IDLE;
            s_res_next.last    = 1'b0;
            s_res_next.is_sine = 1'b0;
        end

        if (take) begin
            if (it.op == nts_pkg::OP_LOAD) begin
                if (gap_busy || tone_busy) begin
                    s_res_next.kind = nts_pkg::KIND_LOAD_BUSY;
                end else begin
                    s_res_next.kind = nts_pkg::KIND_LOAD_OK;
                    gap_pend_next   = nts_pkg::END_W'(it.start) > prev_end_reg;
                    gap_ms_next     = nts_pkg::START_W'(nts_pkg::END_W'(it.start)
                                                        - prev_end_reg);
                    gap_left_next   = '0;
                    tone_left_next  = it.tone_cnt;
                    tone_en_next    = it.freq != '0;
                    step_next       = dv_quot[NSTG];
                    acc_next        = '0;
                    prev_end_next   = nts_pkg::END_W'(it.start) + nts_pkg::END_W'(it.dur);
                end
            end else if (gap_busy) begin
                // silent gap sample
                s_res_next.kind = nts_pkg::KIND_SAMPLE;
                gap_left_next   = (gap_pend_reg ? gap_conv : gap_left_reg)
                                  - nts_pkg::GAP_W'(1);
            end else if (tone_busy) begin
                s_res_next.kind    = nts_pkg::KIND_SAMPLE;
                s_res_next.is_sine = tone_en_reg;
                s_res_next.last    = tone_left_reg == nts_pkg::TONE_W'(1);
                tone_left_next     = tone_left_reg - nts_pkg::TONE_W'(1);
                acc_next           = acc_reg + step_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_valid_reg   <= 1'b0;
            gap_pend_reg  <= 1'b0;
            gap_left_reg  <= '0;
            tone_left_reg <= '0;
            tone_en_reg   <= 1'b0;
            prev_end_reg  <= '0;
            acc_reg       <= '0;
            step_reg      <= '0;
        end else begin
            s_valid_reg   <= s_valid_next;
            gap_pend_reg  <= gap_pend_next;
            gap_left_reg  <= gap_left_next;
            tone_left_reg <= tone_left_next;
            tone_en_reg   <= tone_en_next;
            prev_end_reg  <= prev_end_next;
            acc_reg       <= acc_next;
            step_reg      <= step_next;
        end
        s_res_reg  <= s_res_next;
        gap_ms_reg <= gap_ms_next;
    end

    // table data lands together with the state stage register
    nts_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .aclk (aclk),
        .en   (adv_s),
        .addr (rom_addr),
        .data (rom_data)
    );

    // ---------------------------------------------------------------
    // amplitude scaling and output register
    // ---------------------------------------------------------------
    nts_pkg::kind_t                    sc_kind;
    logic signed [nts_pkg::SAMP_W-1:0] sc_sample;

    nts_sample_scale u_sample_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid_reg),
        .in_ready   (sc_ready),
        .in_res     (s_res_reg),
        .in_entry   (rom_data),
        .amplitude  (amp_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (sc_kind),
        .out_last   (m_tlast),
        .out_sample (sc_sample)
    );

    assign m_tuser = sc_kind;
    assign m_tdata = sc_sample;

`ifndef ASSERT_OFF
    // a pending gap is converted to samples in the very next cycle
    a_gap_pend_once: assert property (@(posedge aclk) disable iff (!aresetn)
        gap_pend_reg |=> !gap_pend_reg)
        else $error("gap conversion pending for more than one cycle");

    // last and table samples come only with sample results
    a_last_is_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid_reg && (s_res_reg.last || s_res_reg.is_sine)
        |-> s_res_reg.kind == nts_pkg::KIND_SAMPLE)
        else $error("last or sine flag on a non-sample result");

    // divider remainder stays below the sample rate
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_valid[NSTG] |-> dv_rem[NSTG] < nts_pkg::RATE_HZ[nts_pkg::REM_W-1:0])
        else $error("phase step divider remainder out of range");

    // every accepted note starts from phase zero
    a_phase_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        load_ok |=> acc_reg == '0)
        else $error("phase accumulator not cleared on note load");
`endif

endmodule

`default_nettype wire

[bench/note_tone_sequencer_unit_test.sv]
`default_nettype none

// note tone sequencer bench: note loads and sample ticks go in on the s_ stream,
// every transfer is predicted in-bench and the m_ stream is checked field by
// field, in order, against the queue of predicted tone results
module note_tone_sequencer_unit_test;

    typedef longint unsigned u64_t;

    localparam int PHASE_BITS = nts_pkg::PHASE_BITS_DEF;
    localparam int SINE_DEPTH = nts_pkg::SINE_DEPTH_DEF;
    localparam int STEP_SHIFT = PHASE_BITS - nts_pkg::FREQ_FRAC_BITS;

    // field widths
    localparam int FREQ_W  = nts_pkg::FREQ_W;
    localparam int START_W = nts_pkg::START_W;
    localparam int DUR_W   = nts_pkg::DUR_W;
    localparam int GAP_W   = nts_pkg::GAP_W;
    localparam int TONE_W  = nts_pkg::TONE_W;
    localparam int END_W   = nts_pkg::END_W;
    localparam int AMP_W   = nts_pkg::AMP_W;

    // fixed-point constants of the tone generator
    localparam u64_t TICK_RATE_HZ = 64'd44100;
    localparam u64_t FULL_SCALE   = 64'd32767;
    localparam u64_t Q30_ONE      = 64'd1 << 30;
    localparam u64_t HALF_PI_Q30  = 64'd1686629713;

    // register map: amplitude is register 0, byte address 4*index
    localparam int         REG_AMPLITUDE = 0;
    localparam logic [2:0] AMP_ADDR      = 3'(4 * REG_AMPLITUDE);

    // run bounds: settle time covers the pipeline depth plus margin
    localparam int SETTLE_CYCLES = PHASE_BITS / 4 + 30;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 50;
    localparam int NUM_PHASES    = 5;

    // one result as it should leave the m_ stream
    typedef struct packed {
        nts_pkg::kind_t kind;
        logic [15:0]    pcm;
        logic           last;
    } tone_result_t;

    // one row of the directed script, repeated reps times
    typedef struct packed {
        logic               op;
        logic [FREQ_W-1:0]  freq;
        logic [START_W-1:0] start;
        logic [DUR_W-1:0]   dur;
        int                 reps;
        bit                 fixed;
        tone_result_t       want;
    } note_row_t;

    localparam tone_result_t NO_RES = '{nts_pkg::KIND_IDLE, 16'd0, 1'b0};
    localparam tone_result_t IDLE_R = '{nts_pkg::KIND_IDLE, 16'd0, 1'b0};
    localparam tone_result_t OK_R   = '{nts_pkg::KIND_LOAD_OK, 16'd0, 1'b0};
    localparam tone_result_t BUSY_R = '{nts_pkg::KIND_LOAD_BUSY, 16'd0, 1'b0};

    localparam int NUM_ROWS = 19;
    localparam note_row_t NOTE_SCRIPT [NUM_ROWS] = '{
        // tick straight after reset: nothing to play
        '{nts_pkg::OP_TICK, 24'd0,       24'd0,       16'd0,      1,  1'b1, IDLE_R},
        // rest of zero duration, then a tick that finds nothing left
        '{nts_pkg::OP_LOAD, 24'd0,       24'd0,       16'd0,      1,  1'b1, OK_R},
        '{nts_pkg::OP_TICK, 24'd0,       24'd0,       16'd0,      1,  1'b1, IDLE_R},
        // 440 Hz for 1 ms, a full-ones load refused while it plays
        '{nts_pkg::OP_LOAD, 24'd112640,  24'd0,       16'd1,      1,  1'b1, OK_R},
        '{nts_pkg::OP_LOAD, 24'hFFFFFF,  24'hFFFFFF,  16'hFFFF,   1,  1'b1, BUSY_R},
        '{nts_pkg::OP_TICK, 24'd0,       24'd0,       16'd0,      44, 1'b0, NO_RES},
        '{nts_pkg::OP_TICK, 24'hFFFFFF,  24'hFFFFFF,  16'hFFFF,   1,  1'b1, IDLE_R},
        // top frequency after a 1 ms gap, an all-zero load refused meanwhile
        '{nts_pkg::OP_LOAD, 24'hFFFFFF,  24'd2,       16'd1,      1,  1'b1, OK_R},
        '{nts_pkg::OP_LOAD, 24'd0,       24'd0,       16'd0,      1,  1'b1, BUSY_R},
        '{nts_pkg::OP_TICK, 24'd0,       24'd0,       16'd0,      88, 1'b0, NO_RES},
        // rest starting before the previous end pulls previous end back
        '{nts_pkg::OP_LOAD, 24'd0,       24'd0,       16'd1,      1,  1'b1, OK_R},
        '{nts_pkg::OP_TICK, 24'd0,       24'd0,       16'd0,      44, 1'b0, NO_RES},
        // zero duration right at the previous end
        '{nts_pkg::OP_LOAD, 24'd1,       24'd1,       16'd0,      1,  1'b1, OK_R},
        '{nts_pkg::OP_TICK, 24'd0,       24'd0,       16'd0,      1,  1'b1, IDLE_R},
        // slowest nonzero step
        '{nts_pkg::OP_LOAD, 24'd1,       24'd1,       16'd1,      1,  1'b1, OK_R},
        '{nts_pkg::OP_TICK, 24'd0,       24'd0,       16'd0,      44, 1'b0, NO_RES},
        // tone at the nyquist rate
        '{nts_pkg::OP_LOAD, 24'd5644800, 24'd2,       16'd1,      1,  1'b1, OK_R},
        '{nts_pkg::OP_TICK, 24'd0,       24'd0,       16'd0,      44, 1'b0, NO_RES},
        '{nts_pkg::OP_TICK, 24'd0,       24'd0,       16'd0,      1,  1'b1, IDLE_R}
    };

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #10 aclk = ~aclk;

    // block ports, all at a known value from time zero
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // note_freq[23:0], note_start_ms[47:24],
                                  // note_duration_ms[63:48]
    logic [0:0]  s_tuser  = '0;   // opcode[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // sample[15:0]
    logic [1:0]  m_tuser;         // kind[1:0]
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    note_tone_sequencer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // mirror of the note state, advanced once per accepted transfer
    logic [PHASE_BITS-1:0] acc_phase   = '0;
    logic [PHASE_BITS-1:0] acc_step    = '0;
    logic [GAP_W-1:0]      gap_left    = '0;
    logic [TONE_W-1:0]     tone_left   = '0;
    logic                  tone_on     = 1'b0;
    logic [END_W-1:0]      prev_end_ms = '0;
    logic [AMP_W-1:0]      amp_model   = 15'h7FFF;
    int                    sine_rom [SINE_DEPTH];

    tone_result_t pending_results [$];
    int           fault_count      = 0;
    int           productive_count = 0;
    int           cycle_count      = 0;
    int           src_idle_mode    = 2;
    int           sink_idle_mode   = 1;
    int           sink_hold        = 0;

    // idle draw per transfer: none, uniform, or mostly back to back
    function automatic int draw_idle(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 18);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : 0;
        endcase
    endfunction

    // sine table entry: q30 taylor series on the angle folded into one quadrant
    function automatic int sine_table_entry(input u64_t k);
        u64_t turn, quad, f, x, x2, term, mag;
        longint s;
        int n;
        turn = (k << 32) / u64_t'(SINE_DEPTH);
        quad = (turn >> 30) & 64'd3;
        f = turn & (Q30_ONE - 64'd1);
        if (quad[0])
            f = Q30_ONE - f;
        x = (f * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        s = longint'(x);
        term = x;
        for (n = 3; n <= 13; n += 2) begin
            term = (term * x2) >> 30;
            term = term / u64_t'((n - 1) * n);
            // odd powers alternate in sign, starting negative at x^3
            if ((((n - 1) / 2) & 1) != 0)
                s -= longint'(term);
            else
                s += longint'(term);
        end
        if (s < 0)
            s = 0;
        mag = (u64_t'(s) * FULL_SCALE + (Q30_ONE >> 1)) >> 30;
        if (mag > FULL_SCALE)
            mag = FULL_SCALE;
        return (quad >= 64'd2) ? -int'(mag) : int'(mag);
    endfunction

    function automatic u64_t ms_as_samples(input u64_t ms);
        return ms * 64'd441 / 64'd10;
    endfunction

    // floor(freq * 2^PHASE_BITS / (256 * rate)) without overflow
    function automatic logic [PHASE_BITS-1:0] phase_step_of(input logic [FREQ_W-1:0] freq);
        u64_t whole, rem;
        whole = u64_t'(freq) / TICK_RATE_HZ;
        rem = u64_t'(freq) % TICK_RATE_HZ;
        return PHASE_BITS'((whole << STEP_SHIFT) + ((rem << STEP_SHIFT) / TICK_RATE_HZ));
    endfunction

    // expected result of one transfer, advancing the mirrored note state
    function automatic tone_result_t predict_tone_step(
        input logic               op,
        input logic [FREQ_W-1:0]  freq,
        input logic [START_W-1:0] start,
        input logic [DUR_W-1:0]   dur
    );
        tone_result_t res;
        int entry;
        u64_t mag;
        res = NO_RES;
        if (op == nts_pkg::OP_LOAD) begin
            if (gap_left != 0 || tone_left != 0) begin
                res.kind = nts_pkg::KIND_LOAD_BUSY;
            end else begin
                gap_left = (END_W'(start) > prev_end_ms)
                    ? GAP_W'(ms_as_samples(u64_t'(start) - u64_t'(prev_end_ms))) : '0;
                tone_left = TONE_W'(ms_as_samples(u64_t'(dur)));
                tone_on = (freq != 0);
                acc_step = phase_step_of(freq);
                acc_phase = '0;
                prev_end_ms = END_W'(start) + END_W'(dur);
                res.kind = nts_pkg::KIND_LOAD_OK;
            end
        end else if (gap_left != 0) begin
            gap_left--;
            res.kind = nts_pkg::KIND_SAMPLE;
        end else if (tone_left != 0) begin
            if (tone_on) begin
                entry = sine_rom[(u64_t'(acc_phase) * u64_t'(SINE_DEPTH)) >> PHASE_BITS];
                // scale the magnitude, truncating toward zero
                mag = u64_t'(entry < 0 ? -entry : entry) * u64_t'(amp_model) / FULL_SCALE;
                res.pcm = (entry < 0) ? -16'(mag) : 16'(mag);
            end
            acc_phase = acc_phase + acc_step;
            tone_left--;
            res.last = (tone_left == 0);
            res.kind = nts_pkg::KIND_SAMPLE;
        end
        return res;
    endfunction

    task automatic log_fault(input string msg);
        if (fault_count < 10)
            $display("%s", msg);
        fault_count++;
    endtask

    // one s_ transfer after a random pause, predicted at the accepting edge
    task automatic send_note_item(
        input logic               op,
        input logic [FREQ_W-1:0]  freq,
        input logic [START_W-1:0] start,
        input logic [DUR_W-1:0]   dur,
        input bit                 fixed,
        input tone_result_t       fixed_res
    );
        int gap;
        tone_result_t res;
        gap = draw_idle(src_idle_mode);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {dur, start, freq};
        do @(posedge aclk); while (!s_tready);
        res = predict_tone_step(op, freq, start, dur);
        if (res.kind == nts_pkg::KIND_SAMPLE || res.kind == nts_pkg::KIND_LOAD_OK)
            productive_count++;
        pending_results.push_back(fixed ? fixed_res : res);
    endtask

    task automatic send_tick();
        send_note_item(nts_pkg::OP_TICK, 24'($urandom()), 24'($urandom()),
            16'($urandom()), 1'b0, NO_RES);
    endtask

    // load with random fields, only while a note is still playing
    task automatic send_refused_load();
        send_note_item(nts_pkg::OP_LOAD, 24'($urandom()), 24'($urandom()),
            16'($urandom()), 1'b0, NO_RES);
    endtask

    // hold the sender until every predicted result has come out
    task automatic settle_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic amp_reg_write(input logic [AMP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AMP_ADDR;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        amp_model = value;
    endtask

    task automatic amp_reg_readback();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AMP_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(amp_model))
            log_fault($sformatf("amplitude readback: expected %0d actual %0d", amp_model, got));
    endtask

    // mostly well-formed notes that are played out, plus some noise;
    // optionally the sender pauses once halfway until the pipeline is empty
    task automatic play_random_notes(input int target, input bit pause_midway);
        int first, drain, busy_at, i, n, pick;
        logic [FREQ_W-1:0]  freq;
        logic [START_W-1:0] start;
        logic [DUR_W-1:0]   dur;
        bit paused;
        first = productive_count;
        paused = 1'b0;
        while (productive_count - first < target) begin
            if (pause_midway && !paused && productive_count - first >= target / 2) begin
                settle_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    freq = '0;
                else if (pick < 5)
                    freq = 24'($urandom());
                else
                    freq = 24'($urandom_range(5120, 1048576));
                // start at, just after, or before the previous end
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    start = START_W'(prev_end_ms);
                else if (pick < 9)
                    start = START_W'(prev_end_ms) + 24'd1;
                else
                    start = 24'($urandom_range(0, int'(prev_end_ms)));
                pick = $urandom_range(0, 19);
                dur = (pick < 5) ? 16'd0 : (pick < 18) ? 16'd1 : 16'd2;
                send_note_item(nts_pkg::OP_LOAD, freq, start, dur, 1'b0, NO_RES);
                drain = int'(gap_left) + int'(tone_left);
                busy_at = ($urandom_range(0, 3) == 0 && drain > 0)
                    ? $urandom_range(0, drain - 1) : -1;
                drain += $urandom_range(0, 2);
                for (i = 0; i < drain; i++) begin
                    if (i == busy_at && (gap_left != 0 || tone_left != 0))
                        send_refused_load();
                    send_tick();
                end
            end else begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    if ((gap_left != 0 || tone_left != 0) && $urandom_range(0, 1) == 1)
                        send_refused_load();
                    else
                        send_tick();
                end
            end
        end
    endtask

    // result side: random stalls on m_tready, check on every transfer
    always @(posedge aclk) begin : result_sink
        int stall;
        tone_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    log_fault($sformatf("unexpected result: kind %0d sample %0d last %0d",
                        m_tuser, $signed(m_tdata), m_tlast));
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.kind || m_tdata !== want.pcm || m_tlast !== want.last)
                        log_fault($sformatf(
                            "result mismatch: kind %0d/%0d sample %0d/%0d last %0d/%0d (exp/act)",
                            want.kind, m_tuser, $signed(want.pcm), $signed(m_tdata),
                            want.last, m_tlast));
                end
                stall = draw_idle(sink_idle_mode);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    sink_hold = stall - 1;
                end
            end else if (!m_tready) begin
                if (sink_hold == 0)
                    m_tready <= 1'b1;
                else
                    sink_hold--;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int k, r, p;
        logic [AMP_W-1:0] amp;
        for (k = 0; k < SINE_DEPTH; k++)
            sine_rom[k] = sine_table_entry(u64_t'(k));

        // reset held low once, then released
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // amplitude comes out of reset at full scale
        amp_reg_readback();

        // directed script at the reset amplitude
        for (r = 0; r < NUM_ROWS; r++) begin
            for (k = 0; k < NOTE_SCRIPT[r].reps; k++)
                send_note_item(NOTE_SCRIPT[r].op, NOTE_SCRIPT[r].freq, NOTE_SCRIPT[r].start,
                    NOTE_SCRIPT[r].dur, NOTE_SCRIPT[r].fixed, NOTE_SCRIPT[r].want);
        end

        // random phases, each at its own amplitude and idle pattern
        for (p = 0; p < NUM_PHASES; p++) begin
            settle_results();
            case (p)
                0: amp = 15'd0;
                1: amp = 15'd1;
                2: amp = 15'h7FFF;
                default: amp = 15'($urandom_range(2, 32766));
            endcase
            amp_reg_write(amp);
            amp_reg_readback();
            src_idle_mode  = p % 3;
            sink_idle_mode = (p + 1) % 3;
            play_random_notes(PHASE_ITEMS, p == 1);
        end

        // let the last transfers drain, then a little slack for strays
        settle_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            log_fault($sformatf("%0d results never arrived", pending_results.size()));
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/nts_pkg.sv
rtl/nts_div_stage.sv
rtl/nts_sine_rom.sv
rtl/nts_sample_scale.sv
rtl/note_tone_sequencer_unit.sv
bench/note_tone_sequencer_unit_test.sv
